// ----- rtl/core/cpu8080_subset_execute_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 8080 subset execution unit
// ----------------------------------------------------------------------------
`ifndef CPU8080_SUBSET_EXECUTE_ASSERT_SVH
`define CPU8080_SUBSET_EXECUTE_ASSERT_SVH

// condition in this cycle implies consequence in the next cycle
`define CPU8080_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cpu8080 subset execute: next-cycle check failed");

// condition implies consequence in the same cycle
`define CPU8080_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cpu8080 subset execute: same-cycle check failed");

`endif

// ----- rtl/core/c8080sx_pkg.sv -----
// ----------------------------------------------------------------------------
// c8080sx_pkg
// Shared types, opcodes and the 8-bit adder for the 8080 subset unit.
// ----------------------------------------------------------------------------
package c8080sx_pkg;

    localparam int MEM_ADDR_BITS_DEF = 15;

    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_LXI_B   = 8'h01;
    localparam logic [7:0] OP_MVI_B   = 8'h06;
    localparam logic [7:0] OP_LXI_D   = 8'h11;
    localparam logic [7:0] OP_LDAX_D  = 8'h1A;
    localparam logic [7:0] OP_LXI_H   = 8'h21;
    localparam logic [7:0] OP_LXI_SP  = 8'h31;
    localparam logic [7:0] OP_MOV_BC  = 8'h41;
    localparam logic [7:0] OP_MOV_BD  = 8'h42;
    localparam logic [7:0] OP_MOV_BE  = 8'h43;
    localparam logic [7:0] OP_MOV_MA  = 8'h77;
    localparam logic [7:0] OP_ADD_B   = 8'h80;
    localparam logic [7:0] OP_ADD_C   = 8'h81;
    localparam logic [7:0] OP_ADD_D   = 8'h82;
    localparam logic [7:0] OP_ADD_E   = 8'h83;
    localparam logic [7:0] OP_ADD_H   = 8'h84;
    localparam logic [7:0] OP_ADD_L   = 8'h85;
    localparam logic [7:0] OP_ADD_M   = 8'h86;
    localparam logic [7:0] OP_JMP     = 8'hC3;
    localparam logic [7:0] OP_ADI     = 8'hC6;
    localparam logic [7:0] OP_CALL    = 8'hCD;

    localparam logic OPER_LOAD = 1'b0;
    localparam logic OPER_STEP = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_UNIMP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP,
        ST_B1,
        ST_B2,
        ST_PUSH,
        ST_DATA,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic z;
        logic s;
        logic p;
        logic cy;
    } t_flags;

    typedef struct packed {
        logic [7:0]  a;
        logic [15:0] pc;
        logic [15:0] sp;
        t_flags      flags;
    } t_arch;

    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic err;
    } t_core_stat;

    typedef struct packed {
        logic [7:0] sum;
        t_flags     flags;
    } t_add_res;

    function automatic t_add_res add8(input logic [7:0] x, input logic [7:0] y);
        logic [8:0] s;
        t_add_res   res;
        s            = {1'b0, x} + {1'b0, y};
        res.sum      = s[7:0];
        res.flags.z  = (s[7:0] == 8'h00);
        res.flags.s  = s[7];
        res.flags.p  = ~^s[7:0];
        res.flags.cy = s[8];
        return res;
    endfunction

endpackage

// ----- rtl/core/c8080sx_ram.sv -----
// ----------------------------------------------------------------------------
// c8080sx_ram
// Single-port byte memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module c8080sx_ram #(
    parameter int MEM_ADDR_BITS = c8080sx_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  c8080sx_pkg::t_mem_req i_req,
    output logic [7:0]            o_rdata
);

    localparam int Depth = 2 ** MEM_ADDR_BITS;

    logic [7:0]               r_mem [0:Depth-1];
    logic [7:0]               r_rdata;
    logic [MEM_ADDR_BITS-1:0] addr;

    assign addr = i_req.addr[MEM_ADDR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[addr] <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/c8080sx_core.sv -----
// ----------------------------------------------------------------------------
// c8080sx_core
// Instruction sequencer and register file; drives the byte memory port.
// ----------------------------------------------------------------------------
module c8080sx_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_operation,
    input  logic [14:0]             i_address,
    input  logic [7:0]              i_data,
    input  logic                    i_slot_free,
    input  logic [7:0]              i_rdata,
    output c8080sx_pkg::t_mem_req   o_req,
    output c8080sx_pkg::t_core_stat o_stat,
    output c8080sx_pkg::t_arch      o_arch
);

    c8080sx_pkg::t_state r_state, n_state;
    logic [7:0]  r_op, n_op;
    logic [7:0]  r_b1, n_b1;
    logic [7:0]  r_b2, n_b2;
    logic        r_err, n_err;
    logic [7:0]  r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d;
    logic [7:0]  r_e, n_e, r_h, n_h, r_l, n_l;
    logic [15:0] r_pc, n_pc, r_sp, n_sp;
    c8080sx_pkg::t_flags r_flags, n_flags;

    logic [15:0] pc_p1, pc_p2, pc_p3, sp_m1, sp_m2;
    logic [7:0]  add_src;
    c8080sx_pkg::t_add_res add_reg, add_rd;
    logic        done;

    assign pc_p1 = r_pc + 16'd1;
    assign pc_p2 = r_pc + 16'd2;
    assign pc_p3 = r_pc + 16'd3;
    assign sp_m1 = r_sp - 16'd1;
    assign sp_m2 = r_sp - 16'd2;

    always_comb begin
        unique case (i_rdata[2:0])
            3'd0:    add_src = r_b;
            3'd1:    add_src = r_c;
            3'd2:    add_src = r_d;
            3'd3:    add_src = r_e;
            3'd4:    add_src = r_h;
            3'd5:    add_src = r_l;
            default: add_src = r_b;
        endcase
    end

    assign add_reg = c8080sx_pkg::add8(r_a, add_src);
    assign add_rd  = c8080sx_pkg::add8(r_a, i_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c8080sx_pkg::ST_IDLE;
            r_err   <= 1'b0;
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_d     <= '0;
            r_e     <= '0;
            r_h     <= '0;
            r_l     <= '0;
            r_pc    <= '0;
            r_sp    <= '0;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
            r_a     <= n_a;
            r_b     <= n_b;
            r_c     <= n_c;
            r_d     <= n_d;
            r_e     <= n_e;
            r_h     <= n_h;
            r_l     <= n_l;
            r_pc    <= n_pc;
            r_sp    <= n_sp;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_b1 <= n_b1;
        r_b2 <= n_b2;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_b1    = r_b1;
        n_b2    = r_b2;
        n_err   = r_err;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_d     = r_d;
        n_e     = r_e;
        n_h     = r_h;
        n_l     = r_l;
        n_pc    = r_pc;
        n_sp    = r_sp;
        n_flags = r_flags;
        o_req   = '0;
        done    = 1'b0;

        unique case (r_state)
            c8080sx_pkg::ST_IDLE: begin
                if (i_accept) begin
                    if (i_operation == c8080sx_pkg::OPER_LOAD) begin
                        o_req = '{en: 1'b1, we: 1'b1, addr: {1'b0, i_address},
                                  wdata: i_data};
                        done  = 1'b1;
                    end else begin
                        o_req   = '{en: 1'b1, we: 1'b0, addr: r_pc, wdata: 8'h00};
                        n_state = c8080sx_pkg::ST_OP;
                    end
                end
            end
            c8080sx_pkg::ST_OP: begin
                n_op    = i_rdata;
                n_err   = c8080sx_pkg::STATUS_OK;
                n_state = c8080sx_pkg::ST_DONE;
                unique case (i_rdata)
                    c8080sx_pkg::OP_NOP: begin
                        n_pc = pc_p1;
                    end
                    c8080sx_pkg::OP_LXI_B, c8080sx_pkg::OP_LXI_D,
                    c8080sx_pkg::OP_LXI_H, c8080sx_pkg::OP_LXI_SP,
                    c8080sx_pkg::OP_MVI_B, c8080sx_pkg::OP_JMP,
                    c8080sx_pkg::OP_CALL, c8080sx_pkg::OP_ADI: begin
                        o_req   = '{en: 1'b1, we: 1'b0, addr: pc_p1, wdata: 8'h00};
                        n_state = c8080sx_pkg::ST_B1;
                    end
                    c8080sx_pkg::OP_LDAX_D: begin
                        o_req   = '{en: 1'b1, we: 1'b0, addr: {r_d, r_e}, wdata: 8'h00};
                        n_state = c8080sx_pkg::ST_DATA;
                    end
                    c8080sx_pkg::OP_ADD_M: begin
                        o_req   = '{en: 1'b1, we: 1'b0, addr: {r_h, r_l}, wdata: 8'h00};
                        n_state = c8080sx_pkg::ST_DATA;
                    end
                    c8080sx_pkg::OP_MOV_BC: begin
                        n_b  = r_c;
                        n_pc = pc_p1;
                    end
                    c8080sx_pkg::OP_MOV_BD: begin
                        n_b  = r_d;
                        n_pc = pc_p1;
                    end
                    c8080sx_pkg::OP_MOV_BE: begin
                        n_b  = r_e;
                        n_pc = pc_p1;
                    end
                    c8080sx_pkg::OP_MOV_MA: begin
                        o_req = '{en: 1'b1, we: 1'b1, addr: {r_h, r_l}, wdata: r_a};
                        n_pc  = pc_p1;
                    end
                    c8080sx_pkg::OP_ADD_B, c8080sx_pkg::OP_ADD_C,
                    c8080sx_pkg::OP_ADD_D, c8080sx_pkg::OP_ADD_E,
                    c8080sx_pkg::OP_ADD_H, c8080sx_pkg::OP_ADD_L: begin
                        n_a     = add_reg.sum;
                        n_flags = add_reg.flags;
                        n_pc    = pc_p1;
                    end
                    default: begin
                        n_err = c8080sx_pkg::STATUS_UNIMP;
                    end
                endcase
            end
            c8080sx_pkg::ST_B1: begin
                n_b1 = i_rdata;
                priority case (r_op)
                    c8080sx_pkg::OP_MVI_B: begin
                        n_b     = i_rdata;
                        n_pc    = pc_p2;
                        n_state = c8080sx_pkg::ST_DONE;
                    end
                    c8080sx_pkg::OP_ADI: begin
                        n_a     = add_rd.sum;
                        n_flags = add_rd.flags;
                        n_pc    = pc_p2;
                        n_state = c8080sx_pkg::ST_DONE;
                    end
                    default: begin
                        o_req   = '{en: 1'b1, we: 1'b0, addr: pc_p2, wdata: 8'h00};
                        n_state = c8080sx_pkg::ST_B2;
                    end
                endcase
            end
            c8080sx_pkg::ST_B2: begin
                n_b2    = i_rdata;
                n_state = c8080sx_pkg::ST_DONE;
                priority case (r_op)
                    c8080sx_pkg::OP_LXI_B: begin
                        n_c  = r_b1;
                        n_b  = i_rdata;
                        n_pc = pc_p3;
                    end
                    c8080sx_pkg::OP_LXI_D: begin
                        n_e  = r_b1;
                        n_d  = i_rdata;
                        n_pc = pc_p3;
                    end
                    c8080sx_pkg::OP_LXI_H: begin
                        n_l  = r_b1;
                        n_h  = i_rdata;
                        n_pc = pc_p3;
                    end
                    c8080sx_pkg::OP_LXI_SP: begin
                        n_sp = {i_rdata, r_b1};
                        n_pc = pc_p3;
                    end
                    c8080sx_pkg::OP_JMP: begin
                        n_pc = {i_rdata, r_b1};
                    end
                    c8080sx_pkg::OP_CALL: begin
                        o_req   = '{en: 1'b1, we: 1'b1, addr: sp_m1, wdata: pc_p3[15:8]};
                        n_state = c8080sx_pkg::ST_PUSH;
                    end
                    default: begin
                        n_state = c8080sx_pkg::ST_DONE;
                    end
                endcase
            end
            c8080sx_pkg::ST_PUSH: begin
                o_req   = '{en: 1'b1, we: 1'b1, addr: sp_m2, wdata: pc_p3[7:0]};
                n_sp    = sp_m2;
                n_pc    = {r_b2, r_b1};
                n_state = c8080sx_pkg::ST_DONE;
            end
            c8080sx_pkg::ST_DATA: begin
                if (r_op == c8080sx_pkg::OP_LDAX_D) begin
                    n_a = i_rdata;
                end else begin
                    n_a     = add_rd.sum;
                    n_flags = add_rd.flags;
                end
                n_pc    = pc_p1;
                n_state = c8080sx_pkg::ST_DONE;
            end
            c8080sx_pkg::ST_DONE: begin
                if (i_slot_free) begin
                    done    = 1'b1;
                    n_state = c8080sx_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = c8080sx_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stat.busy = (r_state != c8080sx_pkg::ST_IDLE);
    assign o_stat.done = done;
    assign o_stat.err  = (r_state == c8080sx_pkg::ST_DONE) ? r_err : c8080sx_pkg::STATUS_OK;

    assign o_arch.a     = r_a;
    assign o_arch.pc    = r_pc;
    assign o_arch.sp    = r_sp;
    assign o_arch.flags = r_flags;

endmodule

// ----- rtl/core/cpu8080_subset_execute.sv -----
// ----------------------------------------------------------------------------
// cpu8080_subset_execute
// Executes a subset of 8080 instructions out of an on-chip byte memory.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): a word is a load (i_operation 0,
// writes i_data at i_address) or a step (i_operation 1, runs the instruction
// at pc). Output channel (o_out_valid / i_out_stall): one word per input word,
// with status and A, pc, sp and flags after that word.
// All instruction bytes and data go through one single-port memory with
// registered read data, one access per cycle; that port sets the timing.
// A load completes on accept. A step fetches the opcode, then the operand
// bytes (one for MVI B and ADI, two for LXI, JMP and CALL) or the data byte
// for LDAX D and ADD M; CALL then pushes the return address. One word is in
// flight at a time; the next word is taken once the sequencer is idle again.
// The result register frees the sequencer while a result waits; while it is
// stalled and full, a finished instruction holds and o_in_stall stays high.
// Reset clears A..L, pc, sp and flags; memory contents are undefined until
// loaded. No clearing pass.
// ----------------------------------------------------------------------------
module cpu8080_subset_execute #(
    parameter int MEM_ADDR_BITS = c8080sx_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [14:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [7:0]  o_accumulator,
    output logic [15:0] o_program_counter,
    output logic [15:0] o_stack_pointer,
    output logic        o_zero_flag,
    output logic        o_sign_flag,
    output logic        o_parity_flag,
    output logic        o_carry_flag
);

    c8080sx_pkg::t_mem_req   mem_req;
    c8080sx_pkg::t_core_stat core_stat;
    c8080sx_pkg::t_arch      arch;
    logic [7:0]              rdata;
    logic                    accept;
    logic                    slot_free;

    logic               r_out_valid;
    logic               r_status;
    c8080sx_pkg::t_arch r_out;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !i_rst_n || core_stat.busy || !slot_free;
    assign accept     = i_in_valid && !o_in_stall;

    c8080sx_ram #(
        .MEM_ADDR_BITS(MEM_ADDR_BITS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rdata(rdata)
    );

    c8080sx_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_operation(i_operation),
        .i_address  (i_address),
        .i_data     (i_data),
        .i_slot_free(slot_free),
        .i_rdata    (rdata),
        .o_req      (mem_req),
        .o_stat     (core_stat),
        .o_arch     (arch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_stat.done) begin
            r_status <= core_stat.err;
            r_out    <= arch;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_accumulator     = r_out.a;
    assign o_program_counter = r_out.pc;
    assign o_stack_pointer   = r_out.sp;
    assign o_zero_flag       = r_out.flags.z;
    assign o_sign_flag       = r_out.flags.s;
    assign o_parity_flag     = r_out.flags.p;
    assign o_carry_flag      = r_out.flags.cy;

endmodule

// ----- rtl/core/cpu8080_subset_execute_chk.sv -----
// ----------------------------------------------------------------------------
// cpu8080_subset_execute_chk
// Port-level checks for the 8080 subset execution unit.
// ----------------------------------------------------------------------------
`include "cpu8080_subset_execute_assert.svh"

module cpu8080_subset_execute_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic i_operation,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_status
);

    `CPU8080_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    `CPU8080_ASSERT_SAME(a_in_blocked, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)

    `CPU8080_ASSERT_NEXT(a_step_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_operation, o_in_stall)

    `CPU8080_ASSERT_NEXT(a_load_result, i_clk, i_rst_n, i_in_valid && !o_in_stall && !i_operation, o_out_valid && !o_status)

endmodule

bind cpu8080_subset_execute cpu8080_subset_execute_chk u_chk (.*);
